// ===== rtl/slb_pkg.sv =====
// Shared types and constants for the string literal blanker.
`default_nettype none

package slb_pkg;

    localparam logic [7:0] QUOTE_BYTE   = 8'h27;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] SPACE_BYTE   = 8'h20;

    localparam int GROUP_SLOTS = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELIM_BYTES = 2'd0,
        CFG_DELIM_COUNT = 2'd1,
        CFG_ESC_BYTE    = 2'd2,
        CFG_ESC_ENABLE  = 2'd3
    } cfg_index_t;

    localparam logic [31:0] DELIM_BYTES_RST = 32'd10023;
    localparam logic [2:0]  DELIM_COUNT_RST = 3'd2;
    localparam logic [7:0]  ESC_BYTE_RST    = 8'd92;
    localparam logic        ESC_ENABLE_RST  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Output bytes released by one accepted input byte, slot 0 first.
    typedef struct packed {
        logic [GROUP_SLOTS-1:0][7:0] bytes;
        logic [1:0]                  cnt;
        logic                        last;
    } group_t;

endpackage

`default_nettype wire

// ===== rtl/slb_front.sv =====
// Front end: accepts text bytes, tracks string state and builds output groups.
`default_nettype none

module slb_front
    import slb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire in_item_t               item,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    output      logic                   grp_we,
    output      group_t                 grp
);

    typedef enum logic [2:0] {
        LA_NONE = 3'b001,
        LA_ONE  = 3'b010,
        LA_TWO  = 3'b100
    } la_state_t;

    typedef struct packed {
        logic       in_str;
        logic [7:0] open_delim;
        logic       esc_pend;
    } scan_t;

    typedef struct packed {
        scan_t      st;
        logic [7:0] ob;
    } proc_t;

    logic [31:0] delim_bytes_reg;
    logic [2:0]  delim_count_reg;
    logic [7:0]  esc_byte_reg;
    logic        esc_enable_reg;

    scan_t       scan_reg, scan_next;
    la_state_t   la_reg, la_next;
    logic [7:0]  mid_reg, mid_next;

    function automatic logic is_delim(input logic [7:0] b, input logic [31:0] bytes,
                                      input logic [2:0] count);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if ((count > 3'(i)) && (bytes[8*i +: 8] == b))
                hit = 1'b1;
        end
        return hit && (b != 8'h00);
    endfunction

    function automatic logic [7:0] blank(input logic [7:0] b);
        return (b == NEWLINE_BYTE) ? NEWLINE_BYTE : SPACE_BYTE;
    endfunction

    function automatic proc_t proc(input scan_t s, input logic [7:0] b,
                                   input logic [31:0] bytes, input logic [2:0] count,
                                   input logic [7:0] esc, input logic esc_en);
        proc_t r;
        r.st = s;
        r.ob = b;
        if (s.in_str) begin
            if (s.esc_pend) begin
                r.st.esc_pend = 1'b0;
                r.ob = blank(b);
            end
            else if (b != 8'h00 && esc_en && b == esc) begin
                r.st.esc_pend = 1'b1;
                r.ob = blank(b);
            end
            else if (b == s.open_delim) begin
                r.st.in_str = 1'b0;
                r.st.open_delim = 8'h00;
            end
            else begin
                r.ob = blank(b);
            end
        end
        else if (is_delim(b, bytes, count)) begin
            r.st.in_str = 1'b1;
            r.st.open_delim = b;
        end
        return r;
    endfunction

    always_comb
    begin
        proc_t      r;
        scan_t      s;
        logic [7:0] b;
        s = scan_reg;
        b = item.in_byte;
        la_next = la_reg;
        mid_next = mid_reg;
        grp = '0;
        grp.last = item.in_last;
        case (la_reg)
            LA_NONE:
            begin
                if (!s.in_str && b == QUOTE_BYTE && !item.in_last
                    && is_delim(QUOTE_BYTE, delim_bytes_reg, delim_count_reg)) begin
                    la_next = LA_ONE;
                end
                else begin
                    r = proc(s, b, delim_bytes_reg, delim_count_reg,
                             esc_byte_reg, esc_enable_reg);
                    s = r.st;
                    grp.bytes[0] = r.ob;
                    grp.cnt = 2'd1;
                end
            end
            LA_ONE:
            begin
                if (!item.in_last) begin
                    la_next = LA_TWO;
                    mid_next = b;
                end
                else begin
                    // text ended early: the held quote opens a string
                    s.in_str = 1'b1;
                    s.open_delim = QUOTE_BYTE;
                    grp.bytes[0] = QUOTE_BYTE;
                    r = proc(s, b, delim_bytes_reg, delim_count_reg,
                             esc_byte_reg, esc_enable_reg);
                    s = r.st;
                    grp.bytes[1] = r.ob;
                    grp.cnt = 2'd2;
                end
            end
            LA_TWO:
            begin
                la_next = LA_NONE;
                grp.cnt = 2'd3;
                if (b == QUOTE_BYTE) begin
                    // character literal passes through unchanged
                    grp.bytes[0] = QUOTE_BYTE;
                    grp.bytes[1] = mid_reg;
                    grp.bytes[2] = QUOTE_BYTE;
                end
                else begin
                    s.in_str = 1'b1;
                    s.open_delim = QUOTE_BYTE;
                    grp.bytes[0] = QUOTE_BYTE;
                    r = proc(s, mid_reg, delim_bytes_reg, delim_count_reg,
                             esc_byte_reg, esc_enable_reg);
                    s = r.st;
                    grp.bytes[1] = r.ob;
                    r = proc(s, b, delim_bytes_reg, delim_count_reg,
                             esc_byte_reg, esc_enable_reg);
                    s = r.st;
                    grp.bytes[2] = r.ob;
                end
            end
            default:
            begin
                la_next = LA_NONE;
            end
        endcase
        if (item.in_last) begin
            s = '0;
            la_next = LA_NONE;
            mid_next = 8'h00;
        end
        scan_next = s;
        grp_we = accept && (grp.cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scan_reg <= '0;
            la_reg   <= LA_NONE;
            mid_reg  <= 8'h00;
        end
        else if (accept) begin
            scan_reg <= scan_next;
            la_reg   <= la_next;
            mid_reg  <= mid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            delim_bytes_reg <= DELIM_BYTES_RST;
            delim_count_reg <= DELIM_COUNT_RST;
            esc_byte_reg    <= ESC_BYTE_RST;
            esc_enable_reg  <= ESC_ENABLE_RST;
        end
        else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_DELIM_BYTES: delim_bytes_reg <= cfg_data;
                CFG_DELIM_COUNT: delim_count_reg <= cfg_data[2:0];
                CFG_ESC_BYTE:    esc_byte_reg    <= cfg_data[7:0];
                CFG_ESC_ENABLE:  esc_enable_reg  <= cfg_data[0];
                default:         esc_enable_reg  <= esc_enable_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slb_queue.sv =====
// Small group queue between the front end and the output serializer.
`default_nettype none

module slb_queue
    import slb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire group_t wdata,
    output      logic   full,
    input  wire logic   rd,
    output      group_t rdata,
    output      logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t             mem [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else begin
            if (wr)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (rd)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slb_back.sv =====
// Back end: holds one group and hands its bytes out one per request.
`default_nettype none

module slb_back
    import slb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire group_t    q_data,
    input  wire logic      q_empty,
    output      logic      q_rd,
    input  wire logic      pop,
    output      logic      empty,
    output      out_item_t dout
);

    group_t     cur_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       at_end;
    logic       advance;

    assign at_end  = (idx_reg == cur_reg.cnt - 2'd1);
    assign advance = valid_reg && pop && at_end;
    assign q_rd    = !q_empty && (!valid_reg || advance);

    assign empty         = !valid_reg;
    assign dout.out_byte = cur_reg.bytes[idx_reg];
    assign dout.out_last = cur_reg.last && at_end;

    always_ff @(posedge clk)
    begin
        if (q_rd)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (q_rd) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (advance) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (valid_reg && pop) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/string_literal_blanker.sv =====
// Top level of the string literal blanker.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------
//  input     | push / full           | din  (in_byte, in_last)
//  result    | pop / empty           | dout (out_byte, out_last)
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One text byte is taken per cycle while full is low; each byte yields zero
// to three output bytes, which leave one per cycle while pop is high. The
// output serializer sets the drain rate: the bytes released by one text byte
// leave one per pop, absorbed by the group queue (QUEUE_DEPTH groups).
// Reset clears string state, lookahead and queue; registers return to their
// reset values. Either side may stall without losing a request.
`default_nettype none

module string_literal_blanker
    import slb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output      logic                   full,
    input  wire in_item_t               din,
    output      logic                   empty,
    input  wire logic                   pop,
    output      out_item_t              dout,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    logic   accept;
    logic   grp_we;
    group_t grp;
    group_t q_data;
    logic   q_empty;
    logic   q_rd;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    slb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (din),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grp_we    (grp_we),
        .grp       (grp)
    );

    slb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (grp_we),
        .wdata (grp),
        .full  (full),
        .rd    (q_rd),
        .rdata (q_data),
        .empty (q_empty)
    );

    slb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .dout    (dout)
    );

endmodule

`default_nettype wire
